FILE: design/swr_pkg.sv
// swr_pkg: shared constants and types for the stack_with_remove_by_value block.
// No dependencies; compiled first.
package swr_pkg;

   localparam int DEPTH      = 16;
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam int KIND_W     = 3;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int ENTRY_CNT_W = 5;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [KIND_W-1:0]         kind_type;
   typedef logic [STATUS_W-1:0]       status_type;
   typedef logic [COUNT_W-1:0]        count_type;

   localparam kind_type KIND_PUSH   = 3'd0;
   localparam kind_type KIND_POP    = 3'd1;
   localparam kind_type KIND_REMOVE = 3'd2;
   localparam kind_type KIND_CLEAR  = 3'd3;
   localparam kind_type KIND_PEEK   = 3'd4;

   localparam status_type ST_DONE      = 2'd0;
   localparam status_type ST_POP_EMPTY = 2'd1;
   localparam status_type ST_NO_MATCH  = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic push;    // shift toward the back, new value enters cell 0
      logic pop;     // shift toward the front everywhere
      logic remove;  // compare and close the gap behind the first match
   } cell_cmd_type;

endpackage

FILE: design/swr_if.sv
// Channel interfaces for stack_with_remove_by_value: request and response.
// Depends on swr_pkg.
interface swr_req_if;
   logic                valid;
   logic                ready;
   swr_pkg::kind_type   kind;
   swr_pkg::value_type  value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface swr_rsp_if;
   logic                                valid;
   logic                                ready;
   swr_pkg::status_type                 status;
   logic [swr_pkg::ENTRY_CNT_W-1:0]     entry_count;
   logic                                empty_flag;
   swr_pkg::value_type                  front_value;

   modport source (output valid, output status, output entry_count, output empty_flag,
                   output front_value, input ready);
   modport sink   (input valid, input status, input entry_count, input empty_flag,
                   input front_value, output ready);
endinterface

FILE: design/swr_cell.sv
// swr_cell: one storage position of the list, with its neighbor links.
// Depends on swr_pkg.
module swr_cell (
   input  logic                  clock,
   input  swr_pkg::cell_cmd_type cmd,
   input  swr_pkg::value_type    key,
   input  logic                  occupied,
   input  swr_pkg::value_type    prev_data,
   input  swr_pkg::value_type    next_data,
   input  logic                  hit_in,
   output logic                  hit_out,
   output swr_pkg::value_type    data,
   output swr_pkg::value_type    data_next
);
   import swr_pkg::*;

   value_type data_ff;
   value_type data_in;
   logic      match;
   logic      shift_up;

   // hit_out is high from the first matching cell onward
   assign match    = cmd.remove && occupied && (data_ff == key);
   assign hit_out  = hit_in || match;
   assign shift_up = cmd.pop || (cmd.remove && hit_out);

   always_comb begin
      if (cmd.push) begin
         data_in = prev_data;
      end else if (shift_up) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign data_next = data_in;

endmodule

FILE: design/stack_with_remove_by_value.sv
// stack_with_remove_by_value: newest-first store of up to DEPTH signed 32-bit
// values with push, pop, remove-first-match, clear and peek. For each accepted
// request a row of cells compares all entries against the key at once and
// shifts in parallel, and the response is registered, so one transfer per clock
// is sustained while the response side keeps up. The
// response appears the cycle after the request transfer; a push into a full
// store, a pop on an empty store and a remove without a match leave the
// contents unchanged and are flagged in status. No clearing pass after reset.
module stack_with_remove_by_value (
   input  logic      clock,
   input  logic      reset,
   swr_req_if.sink   req_chan,
   swr_rsp_if.source rsp_chan
);
   import swr_pkg::*;

   count_type    count_ff;
   count_type    count_in;
   logic         rsp_valid_ff;
   status_type   status_ff;
   status_type   status_in;
   count_type    rsp_count_ff;
   value_type    front_ff;
   value_type    front_in;

   logic         req_xfer;
   logic         is_full;
   logic         is_none;
   logic         found;
   cell_cmd_type cmd;

   value_type    data_q [DEPTH];
   value_type    data_nx [DEPTH];
   logic [DEPTH:0] hit;
   logic [DEPTH-1:0] occ;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign is_full = (count_ff == COUNT_W'(DEPTH));
   assign is_none = (count_ff == '0);
   assign found   = hit[DEPTH];

   assign cmd.push   = req_xfer && (req_chan.kind == KIND_PUSH) && !is_full;
   assign cmd.pop    = req_xfer && (req_chan.kind == KIND_POP) && !is_none;
   assign cmd.remove = req_xfer && (req_chan.kind == KIND_REMOVE);

   assign hit[0] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         value_type prev_d;
         value_type next_d;

         assign occ[gi] = (COUNT_W'(gi) < count_ff);

         if (gi == 0) begin : g_head
            assign prev_d = req_chan.value;
         end else begin : g_link_prev
            assign prev_d = data_q[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_tail
            assign next_d = '0;
         end else begin : g_link_next
            assign next_d = data_q[gi+1];
         end

         swr_cell u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .key       (req_chan.value),
            .occupied  (occ[gi]),
            .prev_data (prev_d),
            .next_data (next_d),
            .hit_in    (hit[gi]),
            .hit_out   (hit[gi+1]),
            .data      (data_q[gi]),
            .data_next (data_nx[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      status_in = ST_DONE;
      case (req_chan.kind)
         KIND_PUSH: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         KIND_POP: begin
            if (is_none) begin
               status_in = ST_POP_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (found) begin
               count_in = count_ff - 1'b1;
            end else begin
               status_in = ST_NO_MATCH;
            end
         end
         KIND_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      front_in = (count_in == '0) ? value_type'(0) : data_nx[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
         front_ff     <= front_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.entry_count = ENTRY_CNT_W'(rsp_count_ff);
   assign rsp_chan.empty_flag  = (rsp_count_ff == '0);
   assign rsp_chan.front_value = front_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("entry count above depth");

   a_xfer_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("transfer without response");

   a_push_front: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> (data_q[0] == $past(req_chan.value)) && (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not land at the front");

   a_no_match_keeps: assert property (@(posedge clock) disable iff (reset)
      cmd.remove && !found |=> count_ff == $past(count_ff))
      else $error("failed remove changed the count");

   a_empty_front_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_count_ff == '0) |-> front_ff == '0)
      else $error("empty store reports a front value");

endmodule
